FILE: hw/rtl/pfsb_pkg.sv
// Package for the polar frozen-set construction block.
// Holds default parameters and fixed field widths; no dependencies.
package pfsb_pkg;
    localparam int MAX_LAYERS_DEF = 10;
    localparam int WORD_BITS_DEF  = 64;
    localparam int PROB_W   = 17;
    localparam int LAYER_W  = 4;
    localparam int DIM_W    = 11;
    localparam int WORD_W   = 64;
    localparam int WIDX_W   = 4;
    localparam int VAL_W    = 32;
    localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;
endpackage

FILE: hw/rtl/pfsb_mult.sv
// Registered 32x32 squarer for Bhattacharyya children, both Q1.31 results.
// Depends on pfsb_pkg.
module pfsb_mult (
    input  logic                       aclk,
    input  logic [pfsb_pkg::VAL_W-1:0] x,
    output logic [pfsb_pkg::VAL_W-1:0] y_even,
    output logic [pfsb_pkg::VAL_W-1:0] y_odd
);
    logic [63:0] sq;
    logic [64:0] diff;

    // x*(2-x) = x*2^32 - x*x in raw Q1.31 terms, so one square serves both
    always_comb begin
        sq   = {32'd0, x} * {32'd0, x};
        diff = {1'b0, x, 32'd0} - {1'b0, sq};
    end

    always_ff @(posedge aclk) begin
        y_even <= diff[62:31];
        y_odd  <= sq[62:31];
    end
endmodule

FILE: hw/rtl/polar_frozen_set_bhattacharyya_top.sv
// Top level of polar frozen-set construction by Bhattacharyya values.
// Depends on pfsb_pkg and pfsb_mult.
// channel | ports                                         | dir
// s_      | s_erasure_prob s_layer_count s_code_dimension | in
// m_      | m_frozen_word m_word_index m_last_word        | out
// Steps are accept, expansion parent by parent, ranking
// (one memory read per compare), then packing index by index and word by word.
// The single memory read port sets the ranking time.
// Reset aresetn synchronous, active low; one request at a time, s_ready low while busy.
// m_ stalls hold the packer in the output state.
module polar_frozen_set_bhattacharyya_top #(
    parameter int MAX_LAYERS = pfsb_pkg::MAX_LAYERS_DEF,
    parameter int WORD_BITS  = pfsb_pkg::WORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pfsb_pkg::PROB_W-1:0]  s_erasure_prob,
    input  logic [pfsb_pkg::LAYER_W-1:0] s_layer_count,
    input  logic [pfsb_pkg::DIM_W-1:0]   s_code_dimension,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pfsb_pkg::WORD_W-1:0]  m_frozen_word,
    output logic [pfsb_pkg::WIDX_W-1:0]  m_word_index,
    output logic                         m_last_word
);
    localparam int DEPTH = 1 << MAX_LAYERS;
    localparam int AW = MAX_LAYERS;
    localparam int CW = MAX_LAYERS + 1;
    localparam int BW = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_E_RD, S_E_MUL, S_E_WE, S_E_WO,
        S_R_I, S_R_V, S_R_J, S_P_RD, S_P_BIT, S_OUT
    } state_t;
    typedef logic [pfsb_pkg::LAYER_W-1:0] layer_t;

    state_t state_reg;
    logic [pfsb_pkg::VAL_W-1:0] rel_mem [DEPTH];
    logic                       flag_mem [DEPTH];
    logic [pfsb_pkg::VAL_W-1:0] rd_reg, vi_reg, odd_reg;
    logic                       frd_reg;
    logic [CW-1:0] len_reg, need_reg, idx_reg, j_reg, cj_reg, rank_reg;
    layer_t        layer_reg, n_reg;
    logic [pfsb_pkg::WORD_W-1:0] word_reg;
    logic [BW-1:0] bit_reg;
    logic [pfsb_pkg::WIDX_W-1:0] widx_reg;
    logic [pfsb_pkg::VAL_W-1:0] even_y, odd_y;

    layer_t        n_sat;
    logic [pfsb_pkg::PROB_W-1:0] p_sat;
    logic [31:0]   len_in, dim_in;
    logic [CW-1:0] idx_inc, last_idx, rank_next;
    logic          gt;
    logic [AW-1:0] raddr, waddr;
    logic          we, fwe, fdata;
    logic [pfsb_pkg::VAL_W-1:0] wdata;

    pfsb_mult u_mult (.aclk(aclk), .x(rd_reg), .y_even(even_y), .y_odd(odd_y));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_frozen_word = word_reg;
    assign m_word_index  = widx_reg;
    assign m_last_word   = (idx_reg == last_idx);

    assign n_sat = (s_layer_count > layer_t'(MAX_LAYERS)) ? layer_t'(MAX_LAYERS)
                                                          : s_layer_count;
    assign p_sat = (s_erasure_prob > pfsb_pkg::PROB_ONE) ? pfsb_pkg::PROB_ONE
                                                         : s_erasure_prob;
    assign len_in = 32'd1 << n_sat;
    assign dim_in = 32'(s_code_dimension);

    assign idx_inc   = idx_reg + CW'(1);
    assign last_idx  = len_reg - CW'(1);
    assign gt        = (rd_reg > vi_reg) || (rd_reg == vi_reg && cj_reg < idx_reg);
    assign rank_next = rank_reg + CW'(gt);
    assign fwe       = (state_reg == S_R_J) && (cj_reg == last_idx);
    assign fdata     = (rank_next < need_reg);

    always_comb begin
        raddr = idx_reg[AW-1:0];
        if (state_reg == S_R_V) raddr = '0;
        if (state_reg == S_R_J) raddr = j_reg[AW-1:0];
    end

    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = even_y;
        if (state_reg == S_IDLE) begin
            we = s_valid;
            wdata = {p_sat, 15'd0};
        end else if (state_reg == S_E_WE) begin
            we = 1'b1;
            waddr = AW'({idx_reg, 1'b0});
        end else if (state_reg == S_E_WO) begin
            we = 1'b1;
            wdata = odd_reg;
            waddr = AW'({idx_reg, 1'b1});
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= rel_mem[raddr];
        if (we) rel_mem[waddr] <= wdata;
    end

    always_ff @(posedge aclk) begin
        frd_reg <= flag_mem[idx_reg[AW-1:0]];
        if (fwe) flag_mem[idx_reg[AW-1:0]] <= fdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        n_reg <= n_sat;
                        len_reg <= CW'(len_in);
                        need_reg <= (dim_in >= len_in) ? '0 : CW'(len_in - dim_in);
                        layer_reg <= '0;
                        idx_reg <= '0;
                        state_reg <= (n_sat == '0) ? S_R_I : S_E_RD;
                    end
                end
                S_E_RD: state_reg <= S_E_MUL;
                S_E_MUL: state_reg <= S_E_WE;
                S_E_WE: begin
                    odd_reg <= odd_y;
                    state_reg <= S_E_WO;
                end
                S_E_WO: begin
                    if (idx_reg == '0) begin
                        if (layer_reg + layer_t'(1) == n_reg) begin
                            state_reg <= S_R_I;
                        end else begin
                            layer_reg <= layer_reg + layer_t'(1);
                            idx_reg <= (CW'(2) << layer_reg) - CW'(1);
                            state_reg <= S_E_RD;
                        end
                    end else begin
                        idx_reg <= idx_reg - CW'(1);
                        state_reg <= S_E_RD;
                    end
                end
                S_R_I: state_reg <= S_R_V;
                S_R_V: begin
                    vi_reg <= rd_reg;
                    j_reg <= CW'(1);
                    cj_reg <= '0;
                    rank_reg <= '0;
                    state_reg <= S_R_J;
                end
                S_R_J: begin
                    rank_reg <= rank_next;
                    if (cj_reg == last_idx) begin
                        if (idx_reg == last_idx) begin
                            idx_reg <= '0;
                            word_reg <= '0;
                            bit_reg <= '0;
                            widx_reg <= '0;
                            state_reg <= S_P_RD;
                        end else begin
                            idx_reg <= idx_inc;
                            state_reg <= S_R_I;
                        end
                    end else begin
                        cj_reg <= j_reg;
                        j_reg <= j_reg + CW'(1);
                    end
                end
                S_P_RD: state_reg <= S_P_BIT;
                S_P_BIT: begin
                    word_reg[bit_reg] <= frd_reg;
                    if (idx_reg == last_idx || bit_reg == BW'(WORD_BITS - 1)) begin
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_inc;
                        bit_reg <= bit_reg + BW'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (idx_reg == last_idx) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_inc;
                            bit_reg <= '0;
                            word_reg <= '0;
                            widx_reg <= widx_reg + pfsb_pkg::WIDX_W'(1);
                            state_reg <= S_P_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frozen_word)
            && $stable(m_word_index) && $stable(m_last_word);
    endproperty
    a_out_hold: assert property (p_out_hold);
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid));
    a_state_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(state_reg));
    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_R_J |-> cj_reg < len_reg);
endmodule
